// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst_n is low.
`define TBO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tbo assertion failed");

// Next-cycle implication, disabled while rst_n is low.
`define TBO_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tbo assertion failed");

`endif

// ===== sv/tbo_pkg.sv =====
// Shared constants, types and edge-test tables of the triangle/box overlap test.
// No dependencies.
package tbo_pkg;

    localparam int COORD_WIDTH = 32;

    // config register indexes
    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_MAX_X = 3'd3;
    localparam logic [2:0] REG_MAX_Y = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;

    // edge-cross-axis tests: edge, axis, and the pair of vertices projected
    localparam int NUM_EDGE_TESTS = 9;
    localparam int TEST_EDGE [9] = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
    localparam int TEST_AXIS [9] = '{0, 1, 2, 0, 1, 2, 0, 1, 2};
    localparam int TEST_P    [9] = '{0, 0, 1, 0, 0, 0, 0, 0, 1};
    localparam int TEST_Q    [9] = '{2, 2, 2, 2, 2, 1, 1, 1, 2};

    typedef struct packed {
        logic valid;
        logic sep;
    } t_ctl;

endpackage

// ===== sv/tbo_tri_if.sv =====
// Triangle input channel: valid/ready plus nine vertex coordinates.
// Depends on tbo_pkg.
interface tbo_tri_if #(parameter int CW = tbo_pkg::COORD_WIDTH);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] vert_a_x;
    logic signed [CW-1:0] vert_a_y;
    logic signed [CW-1:0] vert_a_z;
    logic signed [CW-1:0] vert_b_x;
    logic signed [CW-1:0] vert_b_y;
    logic signed [CW-1:0] vert_b_z;
    logic signed [CW-1:0] vert_c_x;
    logic signed [CW-1:0] vert_c_y;
    logic signed [CW-1:0] vert_c_z;

    modport source (output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
                    vert_b_z, vert_c_x, vert_c_y, vert_c_z, input ready);
    modport sink   (input valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
                    vert_b_z, vert_c_x, vert_c_y, vert_c_z, output ready);
endinterface

// ===== sv/tbo_res_if.sv =====
// Result channel: valid/ready plus the overlap bit.
// No dependencies.
interface tbo_res_if;
    logic valid;
    logic ready;
    logic overlaps;

    modport source (output valid, overlaps, input ready);
    modport sink   (input valid, overlaps, output ready);
endinterface

// ===== sv/tbo_apb.sv =====
// APB register file holding the box corners.
// Depends on tbo_pkg.
module tbo_apb #(
    parameter  int CW  = tbo_pkg::COORD_WIDTH,
    localparam int PDW = (CW > 32) ? 64 : 32,
    localparam int ASH = $clog2(PDW / 8),
    localparam int AW  = ASH + 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AW-1:0]        paddr,
    input  logic [PDW-1:0]       pwdata,
    output logic [PDW-1:0]       prdata,
    output logic                 pready,
    output logic signed [CW-1:0] o_bmin [3],
    output logic signed [CW-1:0] o_bmax [3]
);
    logic signed [CW-1:0] r_min [3];
    logic signed [CW-1:0] r_max [3];
    logic [2:0]           idx;
    logic                 wr;

    assign idx    = paddr[AW-1:ASH];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_min[k] <= '0;
                r_max[k] <= '0;
            end
        end else if (wr) begin
            case (idx)
                tbo_pkg::REG_MIN_X: r_min[0] <= pwdata[CW-1:0];
                tbo_pkg::REG_MIN_Y: r_min[1] <= pwdata[CW-1:0];
                tbo_pkg::REG_MIN_Z: r_min[2] <= pwdata[CW-1:0];
                tbo_pkg::REG_MAX_X: r_max[0] <= pwdata[CW-1:0];
                tbo_pkg::REG_MAX_Y: r_max[1] <= pwdata[CW-1:0];
                tbo_pkg::REG_MAX_Z: r_max[2] <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            tbo_pkg::REG_MIN_X: prdata = PDW'(r_min[0]);
            tbo_pkg::REG_MIN_Y: prdata = PDW'(r_min[1]);
            tbo_pkg::REG_MIN_Z: prdata = PDW'(r_min[2]);
            tbo_pkg::REG_MAX_X: prdata = PDW'(r_max[0]);
            tbo_pkg::REG_MAX_Y: prdata = PDW'(r_max[1]);
            tbo_pkg::REG_MAX_Z: prdata = PDW'(r_max[2]);
            default:            prdata = '0;
        endcase
    end

    assign o_bmin = r_min;
    assign o_bmax = r_max;
endmodule

// ===== sv/tbo_front.sv =====
// Front stages: recenter vertices on the box (doubled units), edges, box-axis test.
// Depends on tbo_pkg.
module tbo_front #(
    parameter  int CW = tbo_pkg::COORD_WIDTH,
    localparam int W  = CW + 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_vert [3][3],
    input  logic signed [CW-1:0] i_bmin [3],
    input  logic signed [CW-1:0] i_bmax [3],
    output tbo_pkg::t_ctl        o_ctl,
    output logic signed [W-1:0]  o_v [3][3],
    output logic signed [W-1:0]  o_e [3][3],
    output logic signed [W-1:0]  o_h [3]
);
    logic                r1_valid, r2_valid, r2_sep;
    logic signed [W-1:0] r1_v [3][3];
    logic signed [W-1:0] r1_h [3];
    logic signed [W-1:0] r2_v [3][3];
    logic signed [W-1:0] r2_e [3][3];
    logic signed [W-1:0] r2_h [3];
    logic signed [W-1:0] n1_v [3][3];
    logic signed [W-1:0] n1_h [3];
    logic signed [W-1:0] n2_e [3][3];
    logic signed [W-1:0] c2 [3];
    logic signed [W:0]   vph [3][3];
    logic                n2_sep;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n1_h[k] = W'(i_bmax[k]) - W'(i_bmin[k]);
            c2[k]   = W'(i_bmax[k]) + W'(i_bmin[k]);
            for (int t = 0; t < 3; t++)
                n1_v[t][k] = (W'(i_vert[t][k]) <<< 1) - c2[k];
        end
    end

    // box axes: separated when all three lie beyond +h or all beyond -h
    always_comb begin
        n2_sep = 1'b0;
        for (int k = 0; k < 3; k++) begin
            for (int t = 0; t < 3; t++)
                vph[t][k] = (W + 1)'(r1_v[t][k]) + (W + 1)'(r1_h[k]);
            n2_sep = n2_sep
                | ((r1_v[0][k] > r1_h[k]) & (r1_v[1][k] > r1_h[k]) & (r1_v[2][k] > r1_h[k]))
                | (vph[0][k][W] & vph[1][k][W] & vph[2][k][W]);
            n2_e[0][k] = r1_v[1][k] - r1_v[0][k];
            n2_e[1][k] = r1_v[2][k] - r1_v[1][k];
            n2_e[2][k] = r1_v[0][k] - r1_v[2][k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v   <= n1_v;
            r1_h   <= n1_h;
            r2_v   <= r1_v;
            r2_h   <= r1_h;
            r2_e   <= n2_e;
            r2_sep <= n2_sep;
        end
    end

    assign o_ctl = '{valid: r2_valid, sep: r2_sep};
    assign o_v   = r2_v;
    assign o_e   = r2_e;
    assign o_h   = r2_h;
endmodule

// ===== sv/tbo_back.sv =====
// Back stages: edge-cross-axis products and tests, plane normal, plane-box test.
// Depends on tbo_pkg.
module tbo_back #(
    parameter  int CW  = tbo_pkg::COORD_WIDTH,
    localparam int W   = CW + 5,
    localparam int PW  = 2 * W,
    localparam int SW  = 2 * W + 1,
    localparam int PPW = 2 * W + 1,
    localparam int DW  = 3 * W + 4,
    localparam int NT  = tbo_pkg::NUM_EDGE_TESTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  tbo_pkg::t_ctl       i_ctl,
    input  logic signed [W-1:0] i_v [3][3],
    input  logic signed [W-1:0] i_e [3][3],
    input  logic signed [W-1:0] i_h [3],
    output logic                o_valid,
    output logic                o_overlaps
);
    // stage 3: products
    logic                 r3_valid, r3_bsep;
    logic signed [PW-1:0] r3_pi [NT], r3_pj [NT], r3_qi [NT], r3_qj [NT];
    logic signed [PW-1:0] r3_ri [NT], r3_rj [NT];
    logic signed [PW-1:0] r3_na [3], r3_nb [3];
    logic signed [W-1:0]  r3_v0 [3], r3_h [3];
    logic signed [PW-1:0] n3_pi [NT], n3_pj [NT], n3_qi [NT], n3_qj [NT];
    logic signed [PW-1:0] n3_ri [NT], n3_rj [NT];
    logic signed [PW-1:0] n3_na [3], n3_nb [3];
    // stage 4: sums
    logic                 r4_valid, r4_bsep;
    logic signed [SW-1:0] r4_pp [NT], r4_pq [NT], r4_rad [NT];
    logic signed [SW-1:0] r4_n [3];
    logic signed [W-1:0]  r4_a [3], r4_b [3];
    // stage 5: edge decisions, split plane products
    logic                  r5_valid, r5_sep;
    logic signed [PPW-1:0] r5_lo_l [3], r5_lo_h [3], r5_hi_l [3], r5_hi_h [3];
    logic signed [PPW-1:0] n5_lo_l [3], n5_lo_h [3], n5_hi_l [3], n5_hi_h [3];
    logic                  n5_esep;
    // stage 6: full plane products
    logic                 r6_valid, r6_sep;
    logic signed [DW-1:0] r6_lo [3], r6_hi [3];
    // stage 7: result
    logic                 r7_valid, r7_ovl;
    logic signed [DW-1:0] dmin, dmax;

    genvar g;
    generate
        for (g = 0; g < NT; g++) begin : g_edge
            localparam int EI = tbo_pkg::TEST_EDGE[g];
            localparam int KK = tbo_pkg::TEST_AXIS[g];
            localparam int II = (KK + 1) % 3;
            localparam int JJ = (KK + 2) % 3;
            localparam int PV = tbo_pkg::TEST_P[g];
            localparam int QV = tbo_pkg::TEST_Q[g];
            logic signed [W-1:0] abs_i, abs_j;
            assign abs_i    = i_e[EI][II][W-1] ? -i_e[EI][II] : i_e[EI][II];
            assign abs_j    = i_e[EI][JJ][W-1] ? -i_e[EI][JJ] : i_e[EI][JJ];
            assign n3_pi[g] = PW'(i_e[EI][JJ]) * PW'(i_v[PV][II]);
            assign n3_pj[g] = PW'(i_e[EI][II]) * PW'(i_v[PV][JJ]);
            assign n3_qi[g] = PW'(i_e[EI][JJ]) * PW'(i_v[QV][II]);
            assign n3_qj[g] = PW'(i_e[EI][II]) * PW'(i_v[QV][JJ]);
            assign n3_ri[g] = PW'(abs_j) * PW'(i_h[II]);
            assign n3_rj[g] = PW'(abs_i) * PW'(i_h[JJ]);
        end
        for (g = 0; g < 3; g++) begin : g_norm
            localparam int II = (g + 1) % 3;
            localparam int JJ = (g + 2) % 3;
            assign n3_na[g] = PW'(i_e[0][II]) * PW'(i_e[1][JJ]);
            assign n3_nb[g] = PW'(i_e[0][JJ]) * PW'(i_e[1][II]);
        end
    endgenerate

    // edge tests: separated when both projections exceed rad, or both fall below -rad
    always_comb begin
        logic signed [SW:0] sp, sq;
        n5_esep = 1'b0;
        for (int t = 0; t < NT; t++) begin
            sp = (SW + 1)'(r4_pp[t]) + (SW + 1)'(r4_rad[t]);
            sq = (SW + 1)'(r4_pq[t]) + (SW + 1)'(r4_rad[t]);
            n5_esep = n5_esep
                | ((r4_pp[t] > r4_rad[t]) & (r4_pq[t] > r4_rad[t]))
                | (sp[SW] & sq[SW]);
        end
    end

    // plane products split into low (unsigned) and high (signed) halves of n
    always_comb begin
        logic               npos;
        logic signed [W-1:0] vlo, vhi;
        logic signed [W:0]   nl, nh;
        for (int k = 0; k < 3; k++) begin
            npos = !r4_n[k][SW-1] && (r4_n[k] != '0);
            vlo  = npos ? r4_a[k] : r4_b[k];
            vhi  = npos ? r4_b[k] : r4_a[k];
            nl   = $signed({1'b0, r4_n[k][W-1:0]});
            nh   = r4_n[k][SW-1:W];
            n5_lo_l[k] = PPW'(nl) * PPW'(vlo);
            n5_lo_h[k] = PPW'(nh) * PPW'(vlo);
            n5_hi_l[k] = PPW'(nl) * PPW'(vhi);
            n5_hi_h[k] = PPW'(nh) * PPW'(vhi);
        end
    end

    assign dmin = r6_lo[0] + r6_lo[1] + r6_lo[2];
    assign dmax = r6_hi[0] + r6_hi[1] + r6_hi[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= i_ctl.valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_pi   <= n3_pi;
            r3_pj   <= n3_pj;
            r3_qi   <= n3_qi;
            r3_qj   <= n3_qj;
            r3_ri   <= n3_ri;
            r3_rj   <= n3_rj;
            r3_na   <= n3_na;
            r3_nb   <= n3_nb;
            r3_v0   <= i_v[0];
            r3_h    <= i_h;
            r3_bsep <= i_ctl.sep;
            for (int t = 0; t < NT; t++) begin
                r4_pp[t]  <= SW'(r3_pi[t]) - SW'(r3_pj[t]);
                r4_pq[t]  <= SW'(r3_qi[t]) - SW'(r3_qj[t]);
                r4_rad[t] <= SW'(r3_ri[t]) + SW'(r3_rj[t]);
            end
            for (int k = 0; k < 3; k++) begin
                r4_n[k] <= SW'(r3_na[k]) - SW'(r3_nb[k]);
                r4_a[k] <= -r3_h[k] - r3_v0[k];
                r4_b[k] <= r3_h[k] - r3_v0[k];
            end
            r4_bsep <= r3_bsep;
            r5_lo_l <= n5_lo_l;
            r5_lo_h <= n5_lo_h;
            r5_hi_l <= n5_hi_l;
            r5_hi_h <= n5_hi_h;
            r5_sep  <= r4_bsep | n5_esep;
            for (int k = 0; k < 3; k++) begin
                r6_lo[k] <= (DW'(r5_lo_h[k]) <<< W) + DW'(r5_lo_l[k]);
                r6_hi[k] <= (DW'(r5_hi_h[k]) <<< W) + DW'(r5_hi_l[k]);
            end
            r6_sep <= r5_sep;
            // plane: overlap needs dmin <= 0 and dmax > 0
            r7_ovl <= !r6_sep && (dmin[DW-1] || dmin == '0)
                      && !dmax[DW-1] && (dmax != '0);
        end
    end

    assign o_valid    = r7_valid;
    assign o_overlaps = r7_ovl;
endmodule

// ===== sv/triangle_box_overlap_test_unit.sv =====
// Triangle/axis-aligned box overlap test, fully pipelined.
// Seven register stages, multiplies in stages 3 and 5 only; throughput one triangle
// per cycle while no result waits on a stalled sink.
// A stalled result holds the whole pipeline; no item is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and clears the box to zero.
module triangle_box_overlap_test_unit #(
    parameter  int COORD_WIDTH = tbo_pkg::COORD_WIDTH,
    localparam int PDW = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int AW  = $clog2(PDW / 8) + 3,
    localparam int W   = COORD_WIDTH + 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tbo_tri_if.sink         i_tri,
    tbo_res_if.source       o_res,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [AW-1:0]   paddr,
    input  logic [PDW-1:0]  pwdata,
    output logic [PDW-1:0]  prdata,
    output logic            pready
);
    logic signed [COORD_WIDTH-1:0] bmin [3];
    logic signed [COORD_WIDTH-1:0] bmax [3];
    logic signed [COORD_WIDTH-1:0] vert [3][3];
    logic signed [W-1:0]           fv [3][3];
    logic signed [W-1:0]           fe [3][3];
    logic signed [W-1:0]           fh [3];
    tbo_pkg::t_ctl                 fctl;
    logic                          en, last_valid;

    // whole pipe advances unless a result is waiting on a stalled sink
    assign en          = !last_valid || o_res.ready;
    assign i_tri.ready = en;
    assign o_res.valid = last_valid;

    assign vert[0][0] = i_tri.vert_a_x;
    assign vert[0][1] = i_tri.vert_a_y;
    assign vert[0][2] = i_tri.vert_a_z;
    assign vert[1][0] = i_tri.vert_b_x;
    assign vert[1][1] = i_tri.vert_b_y;
    assign vert[1][2] = i_tri.vert_b_z;
    assign vert[2][0] = i_tri.vert_c_x;
    assign vert[2][1] = i_tri.vert_c_y;
    assign vert[2][2] = i_tri.vert_c_z;

    tbo_apb #(.CW(COORD_WIDTH)) u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_bmin  (bmin),
        .o_bmax  (bmax)
    );

    tbo_front #(.CW(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_tri.valid),
        .i_vert  (vert),
        .i_bmin  (bmin),
        .i_bmax  (bmax),
        .o_ctl   (fctl),
        .o_v     (fv),
        .o_e     (fe),
        .o_h     (fh)
    );

    tbo_back #(.CW(COORD_WIDTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_ctl      (fctl),
        .i_v        (fv),
        .i_e        (fe),
        .i_h        (fh),
        .o_valid    (last_valid),
        .o_overlaps (o_res.overlaps)
    );
endmodule

// ===== sv/tbo_chk.sv =====
// Port-level checker for the overlap test unit, bound to the top level.
// Depends on assert_macros.svh, tbo_tri_if and tbo_res_if.
`include "assert_macros.svh"

module tbo_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    tbo_tri_if.sink   i_tri,
    tbo_res_if.source o_res,
    input logic       pready
);
    // a stalled result holds its value
    `TBO_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, o_res.valid && !o_res.ready, o_res.valid && $stable(o_res.overlaps))
    // with no result pending the unit always takes a triangle
    `TBO_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !o_res.valid, i_tri.ready)
    // reset empties the output stage
    `TBO_ASSERT_NXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_res.valid)
    // config port never waits
    `TBO_ASSERT_IMP(a_pready, i_clk, i_rst_n, 1'b1, pready)
endmodule

bind triangle_box_overlap_test_unit tbo_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_tri   (i_tri),
    .o_res   (o_res),
    .pready  (pready)
);
